// ===== rtl/tos_pkg.sv =====
// Shared types and constants for the TCP option signature block.
package tos_pkg;

  localparam int unsigned SigW   = 64;
  localparam int unsigned CountW = 8;
  localparam int unsigned SkipW  = 4;
  localparam int unsigned CodeW  = 3;

  // Option kinds with a code of their own
  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] KIND_WS   = 8'd3;
  localparam logic [7:0] KIND_TS   = 8'd8;

  // Signature codes
  localparam logic [CodeW-1:0] CODE_UNKNOWN = 3'd0;
  localparam logic [CodeW-1:0] CODE_MSS     = 3'd1;
  localparam logic [CodeW-1:0] CODE_NOP     = 3'd2;
  localparam logic [CodeW-1:0] CODE_WS      = 3'd3;
  localparam logic [CodeW-1:0] CODE_TS      = 3'd4;
  localparam logic [CodeW-1:0] CODE_MSS_STD = 3'd5;
  localparam logic [CodeW-1:0] CODE_EOL     = 3'd6;

  // Bytes skipped after a kind
  localparam logic [SkipW-1:0] SKIP_WS    = 4'd2;
  localparam logic [SkipW-1:0] SKIP_TS    = 4'd9;
  localparam logic [SkipW-1:0] SKIP_MSS   = 4'd1;
  localparam logic [SkipW-1:0] SKIP_LIMIT = 4'd9;

  // MSS value 265 split into its two bytes
  localparam logic [7:0] MSS_STD_HI = 8'd1;
  localparam logic [7:0] MSS_STD_LO = 8'd9;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       is_last;
  } opt_beat_t;

  typedef struct packed {
    logic [SigW-1:0]   signature;
    logic [CountW-1:0] option_count;
    logic              unknown_seen;
  } sig_beat_t;

endpackage

// ===== rtl/tcp_option_signature.sv =====
// Top level of the TCP option signature block: byte parser and result register.
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+---------------------
//  opt     | in        | opt_beat_t   | opt_valid / opt_ready
//  sig     | out       | sig_beat_t   | sig_valid / sig_ready
//
// One option byte is taken per cycle while opt_ready is high; parsing is a single pass of
// combinational logic from the parse state into the next parse state.
// The edge that takes a last beat loads the result register; the result
// is valid from the next cycle on.
// opt_ready drops only while a result waits and sig_ready is low.
// Reset (synchronous) clears the parse state and the result valid.
module tcp_option_signature
  import tos_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      opt_valid,
  output logic      opt_ready,
  input  opt_beat_t opt_beat,
  output logic      sig_valid,
  input  logic      sig_ready,
  output sig_beat_t sig_beat
);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  // Parse state
  logic [SigW-1:0]   sig_accum;
  logic [SkipW-1:0]  skip_left;
  phase_t            mss_phase;
  logic [7:0]        held_first;
  logic [CountW-1:0] code_count;
  logic              unknown_flag;

  logic [SigW-1:0]   sig_accum_next;
  logic [SkipW-1:0]  skip_left_next;
  phase_t            mss_phase_next;
  logic [7:0]        held_first_next;
  logic [CountW-1:0] code_count_next;
  logic              unknown_flag_next;

  // Decoded kind of the current byte
  logic [CodeW-1:0]  kind_code;
  logic [SkipW-1:0]  kind_skip;
  logic              kind_mss;
  logic              kind_unknown;

  logic              do_append;
  logic [CodeW-1:0]  append_code;
  logic              accept;

  assign accept    = opt_valid && opt_ready;
  // Take a new byte whenever the result register is empty or draining
  assign opt_ready = !sig_valid || sig_ready;

  always_comb begin
    kind_code    = CODE_UNKNOWN;
    kind_skip    = '0;
    kind_mss     = 1'b0;
    kind_unknown = 1'b0;
    unique case (opt_beat.option_byte)
      KIND_EOL: kind_code = CODE_EOL;
      KIND_NOP: kind_code = CODE_NOP;
      KIND_MSS: begin
        kind_code = CODE_MSS;
        kind_mss  = 1'b1;
      end
      KIND_WS: begin
        kind_code = CODE_WS;
        kind_skip = SKIP_WS;
      end
      KIND_TS: begin
        kind_code = CODE_TS;
        kind_skip = SKIP_TS;
      end
      default: kind_unknown = 1'b1;
    endcase
  end

  always_comb begin
    skip_left_next    = skip_left;
    mss_phase_next    = mss_phase;
    held_first_next   = held_first;
    unknown_flag_next = unknown_flag;
    do_append         = 1'b0;
    append_code       = kind_code;

    priority if (skip_left != '0) begin
      // Inside an option body: count down and drop the byte
      skip_left_next = skip_left - SkipW'(1);
    end else if (mss_phase == PH_FIRST) begin
      mss_phase_next = PH_KIND;
      if (opt_beat.is_last) begin
        // No room for the MSS value: treat the byte as a kind
        do_append         = 1'b1;
        skip_left_next    = kind_skip;
        unknown_flag_next = unknown_flag || kind_unknown;
      end else begin
        held_first_next = opt_beat.option_byte;
        mss_phase_next  = PH_SECOND;
      end
    end else if (mss_phase == PH_SECOND) begin
      mss_phase_next = PH_KIND;
      skip_left_next = SKIP_MSS;
      if (held_first == MSS_STD_HI && opt_beat.option_byte == MSS_STD_LO) begin
        do_append   = 1'b1;
        append_code = CODE_MSS_STD;
      end
    end else begin
      do_append         = 1'b1;
      skip_left_next    = kind_skip;
      mss_phase_next    = kind_mss ? PH_FIRST : PH_KIND;
      unknown_flag_next = unknown_flag || kind_unknown;
    end

    if (do_append) begin
      sig_accum_next  = {sig_accum[SigW-CodeW-1:0], append_code};
      code_count_next = (code_count == COUNT_MAX) ? code_count
                                                  : code_count + CountW'(1);
    end else begin
      sig_accum_next  = sig_accum;
      code_count_next = code_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_accum    <= '0;
      skip_left    <= '0;
      mss_phase    <= PH_KIND;
      held_first   <= '0;
      code_count   <= '0;
      unknown_flag <= 1'b0;
      sig_valid    <= 1'b0;
    end else begin
      if (sig_valid && sig_ready) begin
        sig_valid <= 1'b0;
      end
      if (accept) begin
        if (opt_beat.is_last) begin
          // Hand the finished signature over and start a fresh area
          sig_beat.signature    <= sig_accum_next;
          sig_beat.option_count <= code_count_next;
          sig_beat.unknown_seen <= unknown_flag_next;
          sig_valid             <= 1'b1;
          sig_accum             <= '0;
          skip_left             <= '0;
          mss_phase             <= PH_KIND;
          held_first            <= '0;
          code_count            <= '0;
          unknown_flag          <= 1'b0;
        end else begin
          sig_accum    <= sig_accum_next;
          skip_left    <= skip_left_next;
          mss_phase    <= mss_phase_next;
          held_first   <= held_first_next;
          code_count   <= code_count_next;
          unknown_flag <= unknown_flag_next;
        end
      end
    end
  end

  // A last byte always produces a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && opt_beat.is_last |=> sig_valid)
    else $error("last byte did not load the result register");

  // Skip counter never exceeds the longest option body
  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    skip_left <= SKIP_LIMIT)
    else $error("skip counter out of range");

  // While skipping, no MSS capture is pending
  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    skip_left != '0 |-> mss_phase == PH_KIND)
    else $error("skip and MSS capture overlap");

  // Without an appended code the signature and flag stay clear
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    code_count == '0 |-> sig_accum == '0 && !unknown_flag)
    else $error("signature changed without a code");

endmodule
